FILE: rtl/cau_pkg.sv
// Shared constants for the complex arithmetic unit: number format, opcodes,
// divider depth and register map. No dependencies.
package cau_pkg;

   // Fixed-point format of every operand and result part
   localparam int FRAC_BITS = 16;

   // Quotient bits resolved by the divider, one per pipeline stage
   localparam int DIV_STEPS = 32;

   // Divider remainder width: 64-bit magnitude scaled up to the top quotient bit
   localparam int REM_W = 64 + DIV_STEPS;

   // Operation codes
   localparam int FUNC_W = 3;
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_NEAR = 3'd4;

   // Register map
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_TOLERANCE = 2'd0;
   localparam logic [30:0] TOLERANCE_RESET = 31'd1;

endpackage

FILE: rtl/cau_req_if.sv
// Operand channel of the complex arithmetic unit: valid/ready plus one
// operation beat. No dependencies.
interface cau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic signed [31:0] a_re;
   logic signed [31:0] a_im;
   logic signed [31:0] b_re;
   logic signed [31:0] b_im;

   modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

FILE: rtl/cau_rsp_if.sv
// Result channel of the complex arithmetic unit: valid/ready plus one
// result beat. No dependencies.
interface cau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_re;
   logic signed [31:0] result_im;
   logic               is_near;
   logic               div_by_zero;
   logic               overflowed;

   modport source (output valid, result_re, result_im, is_near, div_by_zero, overflowed,
                   input ready);
   modport sink   (input valid, result_re, result_im, is_near, div_by_zero, overflowed,
                   output ready);
endinterface

FILE: rtl/cau_div_lane.sv
// One quotient lane of the pipelined restoring divider: a prep stage, then one
// quotient bit per stage. Depends on cau_pkg.
module cau_div_lane import cau_pkg::*; (
   input  logic                 clock,
   input  logic [DIV_STEPS:0]   stage_en,
   input  logic [63:0]          mag,
   input  logic [63:0]          divisor,
   output logic [DIV_STEPS-1:0] quot,
   output logic                 pre_ovf
);

   logic [REM_W-1:0]     rem_ff [DIV_STEPS+1];
   logic [63:0]          dvs_ff [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS+1];
   logic                 ovf_ff [DIV_STEPS+1];

   logic [REM_W-1:0] mag_w;
   logic [REM_W-1:0] ovf_lim;

   // Scale the magnitude; flag quotients that cannot fit the quotient width
   assign mag_w   = {{(REM_W-64){1'b0}}, mag};
   assign ovf_lim = {{(REM_W-64){1'b0}}, divisor} << (DIV_STEPS - FRAC_BITS);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rem_ff[0] <= mag_w << FRAC_BITS;
         dvs_ff[0] <= divisor;
         quo_ff[0] <= '0;
         ovf_ff[0] <= mag_w >= ovf_lim;
      end
   end

   // Resolve one quotient bit per stage, most significant first
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      localparam int SH = DIV_STEPS - k;
      logic [REM_W-1:0] trial;
      logic             fit;

      assign trial = {{(REM_W-64){1'b0}}, dvs_ff[k-1]} << SH;
      assign fit   = rem_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            rem_ff[k] <= fit ? rem_ff[k-1] - trial : rem_ff[k-1];
            dvs_ff[k] <= dvs_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
            quo_ff[k] <= quo_ff[k-1] | ({{(DIV_STEPS-1){1'b0}}, fit} << SH);
         end
      end
   end

   assign quot    = quo_ff[DIV_STEPS];
   assign pre_ovf = ovf_ff[DIV_STEPS];

endmodule

FILE: rtl/complex_arith_unit.sv
// Complex arithmetic unit top level: operand stages, multipliers, sums and two
// divider lanes. Depends on cau_pkg, cau_req_if, cau_rsp_if, cau_div_lane.
// Pipeline: an accepted operand beat passes five operand/multiply/sum stages, 33 divider
// stages and one output register. Throughput: one beat per cycle unless every stage is
// full and the result channel stalls; the 32 one-bit divider stages set the depth.
// Reset: synchronous; clears all stage valid bits and sets tolerance to 1 LSB.
module complex_arith_unit import cau_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cau_req_if.sink               req_bus,
   cau_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int D0   = 5;
   localparam int NSTG = D0 + DIV_STEPS + 2;
   localparam int OUTS = NSTG - 1;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic signed [31:0] ar;
      logic signed [31:0] ai;
      logic signed [31:0] br;
      logic signed [31:0] bi;
   } op_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic signed [31:0] ar;
      logic signed [31:0] ai;
      logic signed [31:0] br;
      logic signed [31:0] bi;
      logic signed [32:0] as_re;
      logic signed [32:0] as_im;
      logic [30:0]        mag_re;
      logic [30:0]        mag_im;
      logic               huge;
      logic               bzero;
   } s1_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic signed [32:0] as_re;
      logic signed [32:0] as_im;
      logic signed [63:0] p_rr;
      logic signed [63:0] p_ii;
      logic signed [63:0] p_ri;
      logic signed [63:0] p_ir;
      logic [63:0]        p_br2;
      logic [63:0]        p_bi2;
      logic [61:0]        q_re;
      logic [61:0]        q_im;
      logic [61:0]        tol2;
      logic               huge;
      logic               bzero;
   } s2_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [31:0]        res_re;
      logic [31:0]        res_im;
      logic               near;
      logic               ovf;
      logic               bzero;
      logic signed [64:0] num_re;
      logic signed [64:0] num_im;
      logic [63:0]        den;
   } s3_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [31:0]       res_re;
      logic [31:0]       res_im;
      logic              near;
      logic              ovf;
      logic              bzero;
      logic              neg_re;
      logic              neg_im;
   } side_type;

   typedef struct packed {
      logic [31:0] res_re;
      logic [31:0] res_im;
      logic        near;
      logic        dz;
      logic        ovf;
   } out_type;

   // Saturate a wide signed value to 32 bits; top bit is the overflow flag
   function automatic logic [32:0] sat32(input logic [64:0] v);
      logic fits;
      fits = (v[64:31] == {34{1'b0}}) || (v[64:31] == {34{1'b1}});
      if (fits) return {1'b0, v[31:0]};
      return {1'b1, v[64] ? 32'h8000_0000 : 32'h7FFF_FFFF};
   endfunction

   // Clamp an unsigned quotient to its signed limit and apply the sign
   function automatic logic [32:0] div_fix(input logic [31:0] q, input logic pre,
                                           input logic neg);
      logic [31:0] lim;
      logic        ov;
      logic [31:0] qs;
      lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      ov  = pre || (q > lim);
      qs  = ov ? lim : q;
      return {ov, neg ? (~qs + 32'd1) : qs};
   endfunction

   // ---------------- configuration ----------------
   logic [30:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOLERANCE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == CSR_ADDR_TOLERANCE) begin
         tol_ff <= csr_pwdata[30:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_TOLERANCE) ? {1'b0, tol_ff} : 32'd0;

   // ---------------- pipeline control ----------------
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] stg_en;

   // A stage loads when some stage at or after it is empty, or the output drains
   always_comb begin
      for (int k = 0; k < NSTG; k++) begin
         logic [NSTG-1:0] mask;
         mask = ~((NSTG'(1) << k) - NSTG'(1));
         stg_en[k] = rsp_bus.ready || ((vld_ff & mask) != mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stg_en[0]) vld_ff[0] <= req_bus.valid;
         for (int k = 1; k < NSTG; k++) begin
            if (stg_en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign req_bus.ready = stg_en[0];

   // ---------------- stage 0: capture operands ----------------
   op_type s0_ff;

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         s0_ff.func <= req_bus.func;
         s0_ff.ar   <= req_bus.a_re;
         s0_ff.ai   <= req_bus.a_im;
         s0_ff.br   <= req_bus.b_re;
         s0_ff.bi   <= req_bus.b_im;
      end
   end

   // ---------------- stage 1: sums, differences, magnitudes ----------------
   s1_type s1_ff, s1_in;

   always_comb begin
      logic signed [32:0] sum_re, sum_im, dif_re, dif_im;
      logic [32:0]        abs_re, abs_im;
      sum_re = {s0_ff.ar[31], s0_ff.ar} + {s0_ff.br[31], s0_ff.br};
      sum_im = {s0_ff.ai[31], s0_ff.ai} + {s0_ff.bi[31], s0_ff.bi};
      dif_re = {s0_ff.ar[31], s0_ff.ar} - {s0_ff.br[31], s0_ff.br};
      dif_im = {s0_ff.ai[31], s0_ff.ai} - {s0_ff.bi[31], s0_ff.bi};
      abs_re = dif_re[32] ? -dif_re : dif_re;
      abs_im = dif_im[32] ? -dif_im : dif_im;
      s1_in.func   = s0_ff.func;
      s1_in.ar     = s0_ff.ar;
      s1_in.ai     = s0_ff.ai;
      s1_in.br     = s0_ff.br;
      s1_in.bi     = s0_ff.bi;
      s1_in.as_re  = (s0_ff.func == FUNC_SUB) ? dif_re : sum_re;
      s1_in.as_im  = (s0_ff.func == FUNC_SUB) ? dif_im : sum_im;
      s1_in.mag_re = abs_re[30:0];
      s1_in.mag_im = abs_im[30:0];
      s1_in.huge   = (|abs_re[32:31]) || (|abs_im[32:31]);
      s1_in.bzero  = (s0_ff.br == 32'sd0) && (s0_ff.bi == 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (stg_en[1]) s1_ff <= s1_in;
   end

   // ---------------- stage 2: products ----------------
   s2_type s2_ff, s2_in;

   always_comb begin
      logic signed [31:0] ar, ai, br, bi;
      logic signed [63:0] rr, ii, ri, ir, bb_r, bb_i;
      ar   = s1_ff.ar;
      ai   = s1_ff.ai;
      br   = s1_ff.br;
      bi   = s1_ff.bi;
      rr   = ar * br;
      ii   = ai * bi;
      ri   = ar * bi;
      ir   = ai * br;
      bb_r = br * br;
      bb_i = bi * bi;
      s2_in.func  = s1_ff.func;
      s2_in.as_re = s1_ff.as_re;
      s2_in.as_im = s1_ff.as_im;
      s2_in.p_rr  = rr;
      s2_in.p_ii  = ii;
      s2_in.p_ri  = ri;
      s2_in.p_ir  = ir;
      s2_in.p_br2 = bb_r;
      s2_in.p_bi2 = bb_i;
      s2_in.q_re  = s1_ff.mag_re * s1_ff.mag_re;
      s2_in.q_im  = s1_ff.mag_im * s1_ff.mag_im;
      s2_in.tol2  = tol_ff * tol_ff;
      s2_in.huge  = s1_ff.huge;
      s2_in.bzero = s1_ff.bzero;
   end

   always_ff @(posedge clock) begin
      if (stg_en[2]) s2_ff <= s2_in;
   end

   // ---------------- stage 3: product sums, saturation, compare ----------------
   s3_type s3_ff, s3_in;

   always_comb begin
      logic signed [63:0] rr, ii, ri, ir;
      logic signed [64:0] mre, mim, fre, fim;
      logic [62:0]        sq_dist;
      logic [32:0]        sre, sim;
      rr   = s2_ff.p_rr;
      ii   = s2_ff.p_ii;
      ri   = s2_ff.p_ri;
      ir   = s2_ff.p_ir;
      mre  = {rr[63], rr} - {ii[63], ii};
      mim  = {ri[63], ri} + {ir[63], ir};
      fre  = mre >>> FRAC_BITS;
      fim  = mim >>> FRAC_BITS;
      sq_dist = {1'b0, s2_ff.q_re} + {1'b0, s2_ff.q_im};
      sre  = '0;
      sim  = '0;
      s3_in.near = 1'b0;
      case (s2_ff.func)
         FUNC_ADD, FUNC_SUB: begin
            sre = sat32({{32{s2_ff.as_re[32]}}, s2_ff.as_re});
            sim = sat32({{32{s2_ff.as_im[32]}}, s2_ff.as_im});
         end
         FUNC_MUL: begin
            sre = sat32(fre);
            sim = sat32(fim);
         end
         FUNC_NEAR: begin
            s3_in.near = !s2_ff.huge && (sq_dist < {1'b0, s2_ff.tol2});
         end
         default: begin
         end
      endcase
      s3_in.func   = s2_ff.func;
      s3_in.res_re = sre[31:0];
      s3_in.res_im = sim[31:0];
      s3_in.ovf    = sre[32] | sim[32];
      s3_in.bzero  = s2_ff.bzero;
      s3_in.num_re = {rr[63], rr} + {ii[63], ii};
      s3_in.num_im = {ir[63], ir} - {ri[63], ri};
      s3_in.den    = s2_ff.p_br2 + s2_ff.p_bi2;
   end

   always_ff @(posedge clock) begin
      if (stg_en[3]) s3_ff <= s3_in;
   end

   // ---------------- stage 4: numerator magnitudes ----------------
   side_type    s4_ff, s4_in;
   logic [63:0] mag_re_ff, mag_im_ff, den_ff;

   always_comb begin
      s4_in.func   = s3_ff.func;
      s4_in.res_re = s3_ff.res_re;
      s4_in.res_im = s3_ff.res_im;
      s4_in.near   = s3_ff.near;
      s4_in.ovf    = s3_ff.ovf;
      s4_in.bzero  = s3_ff.bzero;
      s4_in.neg_re = s3_ff.num_re[64];
      s4_in.neg_im = s3_ff.num_im[64];
   end

   always_ff @(posedge clock) begin
      if (stg_en[4]) begin
         s4_ff     <= s4_in;
         mag_re_ff <= s3_ff.num_re[64] ? 64'(-s3_ff.num_re) : s3_ff.num_re[63:0];
         mag_im_ff <= s3_ff.num_im[64] ? 64'(-s3_ff.num_im) : s3_ff.num_im[63:0];
         den_ff    <= s3_ff.den;
      end
   end

   // ---------------- divider lanes and side line ----------------
   logic [DIV_STEPS-1:0] quo_re, quo_im;
   logic                 pov_re, pov_im;
   side_type             side_ff [DIV_STEPS+1];

   cau_div_lane u_div_re (
      .clock    (clock),
      .stage_en (stg_en[D0 +: DIV_STEPS+1]),
      .mag      (mag_re_ff),
      .divisor  (den_ff),
      .quot     (quo_re),
      .pre_ovf  (pov_re)
   );

   cau_div_lane u_div_im (
      .clock    (clock),
      .stage_en (stg_en[D0 +: DIV_STEPS+1]),
      .mag      (mag_im_ff),
      .divisor  (den_ff),
      .quot     (quo_im),
      .pre_ovf  (pov_im)
   );

   // Carry the non-divide results alongside the divider stages
   always_ff @(posedge clock) begin
      if (stg_en[D0]) side_ff[0] <= s4_ff;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         if (stg_en[D0+k]) side_ff[k] <= side_ff[k-1];
      end
   end

   // ---------------- output register ----------------
   out_type out_ff, out_in;

   always_comb begin
      side_type    sd;
      logic [32:0] qre, qim;
      sd  = side_ff[DIV_STEPS];
      qre = div_fix(quo_re, pov_re, sd.neg_re);
      qim = div_fix(quo_im, pov_im, sd.neg_im);
      out_in.res_re = sd.res_re;
      out_in.res_im = sd.res_im;
      out_in.near   = sd.near;
      out_in.dz     = 1'b0;
      out_in.ovf    = sd.ovf;
      if (sd.func == FUNC_DIV) begin
         if (sd.bzero) begin
            out_in.res_re = '0;
            out_in.res_im = '0;
            out_in.dz     = 1'b1;
            out_in.ovf    = 1'b0;
         end else begin
            out_in.res_re = qre[31:0];
            out_in.res_im = qim[31:0];
            out_in.ovf    = qre[32] | qim[32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[OUTS]) out_ff <= out_in;
   end

   assign rsp_bus.valid       = vld_ff[OUTS];
   assign rsp_bus.result_re   = out_ff.res_re;
   assign rsp_bus.result_im   = out_ff.res_im;
   assign rsp_bus.is_near     = out_ff.near;
   assign rsp_bus.div_by_zero = out_ff.dz;
   assign rsp_bus.overflowed  = out_ff.ovf;

   // ---------------- assertions ----------------
   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.div_by_zero |->
         rsp_bus.result_re == 32'sd0 && rsp_bus.result_im == 32'sd0 && !rsp_bus.overflowed)
      else $error("divide by zero beat carries a nonzero result");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.is_near && (rsp_bus.div_by_zero || rsp_bus.overflowed)))
      else $error("near flag raised together with an arithmetic flag");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (&vld_ff) && !rsp_bus.ready)
      else $error("operand beat refused while the pipeline has room");

endmodule

FILE: test/complex_arith_unit_tb.sv
// Self-checking testbench for complex_arith_unit: directed and random operand beats,
// tolerance register writes over APB, random idling on both channels, scoreboard check.
// Depends on cau_pkg, cau_req_if, cau_rsp_if and the RTL of complex_arith_unit.
`timescale 1ns / 100ps

module complex_arith_unit_tb import cau_pkg::*; ();

   localparam int LATENCY = 39;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } op_beat_type;

   typedef struct packed {
      logic signed [31:0] result_re;
      logic signed [31:0] result_im;
      logic               is_near;
      logic               div_by_zero;
      logic               overflowed;
   } result_beat_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   cau_req_if req_bus ();
   cau_rsp_if rsp_bus ();

   complex_arith_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [30:0]     tol_model;
   result_beat_type expected_results[$];
   int              error_count = 0;
   int              result_count = 0;
   int              op_count[8];
   longint          cycle_count = 0;
   bit              idle_enable = 1'b1;
   bit              hold_off = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abort on runaway run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("complex_arith_unit_tb NOT OK");
         $finish;
      end
   end

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] clamp32(input logic signed [127:0] v, inout logic ov);
      if (v > 128'sd2147483647) begin
         ov = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
         ov = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Quotient of num / den with FRAC_BITS fraction bits, truncated toward zero
   function automatic logic signed [31:0] quotient_part(input logic signed [127:0] num,
                                                        input logic [127:0] den,
                                                        inout logic ov);
      logic [127:0] mag, q;
      logic         neg;
      neg = num < 0;
      mag = neg ? -num : num;
      q = (mag << FRAC_BITS) / den;
      if (!neg && q > 128'h7fffffff) begin
         ov = 1'b1;
         return 32'sh7fffffff;
      end
      if (neg && q > 128'h80000000) begin
         ov = 1'b1;
         return 32'sh80000000;
      end
      return neg ? -q[31:0] : q[31:0];
   endfunction

   // Compute the expected result beat of one operation
   function automatic result_beat_type complex_result(input op_beat_type op);
      result_beat_type r;
      logic signed [127:0] ar, ai, br, bi, pr, pi, dr, di;
      logic [127:0] d2;
      logic ov;
      r = '0;
      ov = 1'b0;
      ar = op.a_re;
      ai = op.a_im;
      br = op.b_re;
      bi = op.b_im;
      case (op.func)
         FUNC_ADD: begin
            r.result_re = clamp32(ar + br, ov);
            r.result_im = clamp32(ai + bi, ov);
         end
         FUNC_SUB: begin
            r.result_re = clamp32(ar - br, ov);
            r.result_im = clamp32(ai - bi, ov);
         end
         FUNC_MUL: begin
            pr = ar * br - ai * bi;
            pi = ar * bi + ai * br;
            r.result_re = clamp32(pr >>> FRAC_BITS, ov);
            r.result_im = clamp32(pi >>> FRAC_BITS, ov);
         end
         FUNC_DIV: begin
            if (br == 0 && bi == 0) begin
               r.div_by_zero = 1'b1;
            end else begin
               d2 = br * br + bi * bi;
               r.result_re = quotient_part(ar * br + ai * bi, d2, ov);
               r.result_im = quotient_part(ai * br - ar * bi, d2, ov);
            end
         end
         FUNC_NEAR: begin
            dr = ar - br;
            di = ai - bi;
            if (dr < 0) dr = -dr;
            if (di < 0) di = -di;
            if (dr < 128'sh80000000 && di < 128'sh80000000)
               r.is_near = (dr * dr + di * di) < (128'(tol_model) * 128'(tol_model));
         end
         default: ;
      endcase
      r.overflowed = ov;
      return r;
   endfunction

   // Send one operand beat, with random idle bursts ahead of it
   task automatic send_op(input op_beat_type op);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= op.func;
      req_bus.a_re  <= op.a_re;
      req_bus.a_im  <= op.a_im;
      req_bus.b_re  <= op.b_re;
      req_bus.b_im  <= op.b_im;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(complex_result(op));
      op_count[op.func]++;
   endtask

   task automatic drop_valid();
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      drop_valid();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // APB write: setup then access
   task automatic write_tolerance(input logic [30:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_TOLERANCE;
      csr_pwdata  <= {1'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tol_model = value;
   endtask

   function automatic logic [31:0] edge_value();
      case ($urandom_range(0, 9))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'h0;
         3: return 32'hffffffff;
         4: return 32'h00010000;
         5: return 32'(signed'($urandom_range(0, 2000)) - 1000);
         6: return 32'(signed'($urandom_range(0, 32'h00100000)) - 32'sh00080000);
         default: return $urandom();
      endcase
   endfunction

   function automatic op_beat_type random_op(input logic [2:0] func);
      op_beat_type op;
      op.func = func;
      op.a_re = edge_value();
      op.a_im = edge_value();
      op.b_re = edge_value();
      op.b_im = edge_value();
      // keep near-compare operands close often enough to hit both outcomes
      if (func == FUNC_NEAR && $urandom_range(0, 1)) begin
         op.b_re = op.a_re + 32'(signed'($urandom_range(0, 200)) - 100);
         op.b_im = op.a_im + 32'(signed'($urandom_range(0, 200)) - 100);
      end
      return op;
   endfunction

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      result_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            $error("result beat with no expectation pending");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.result_re !== want.result_re) begin
               $error("result_re expected %0d got %0d", want.result_re, rsp_bus.result_re);
               error_count++;
            end
            if (rsp_bus.result_im !== want.result_im) begin
               $error("result_im expected %0d got %0d", want.result_im, rsp_bus.result_im);
               error_count++;
            end
            if (rsp_bus.is_near !== want.is_near) begin
               $error("is_near expected %0d got %0d", want.is_near, rsp_bus.is_near);
               error_count++;
            end
            if (rsp_bus.div_by_zero !== want.div_by_zero) begin
               $error("div_by_zero expected %0d got %0d", want.div_by_zero,
                      rsp_bus.div_by_zero);
               error_count++;
            end
            if (rsp_bus.overflowed !== want.overflowed) begin
               $error("overflowed expected %0d got %0d", want.overflowed,
                      rsp_bus.overflowed);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stall bursts, or a long hold-off on request
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 16);
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic test_directed();
      op_beat_type op;
      logic [31:0] ext[4] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
      for (int f = 0; f < 8; f++) begin
         for (int k = 0; k < 2; k++) begin
            op.func = f[2:0];
            op.a_re = ext[k];
            op.a_im = ext[k + 1];
            op.b_re = ext[3 - k];
            op.b_im = ext[k];
            send_op(op);
         end
      end
      // zero divisor
      op = '{FUNC_DIV, 32'h00030000, -32'sh00020000, 32'h0, 32'h0};
      send_op(op);
      // near: equal operands, one LSB apart, huge distance
      op = '{FUNC_NEAR, 32'h100, 32'h200, 32'h100, 32'h200};
      send_op(op);
      op = '{FUNC_NEAR, 32'h100, 32'h200, 32'h101, 32'h200};
      send_op(op);
      op = '{FUNC_NEAR, 32'h7fffffff, 32'h0, 32'h80000000, 32'h0};
      send_op(op);
      // tiny divisor forces quotient saturation
      op = '{FUNC_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0};
      send_op(op);
      wait_drained();
   endtask

   task automatic test_random_ops(input int count);
      for (int i = 0; i < count; i++) send_op(random_op(3'($urandom_range(0, 7))));
   endtask

   task automatic test_tolerance_settings();
      logic [30:0] tols[5] = '{31'd0, 31'h7fffffff, 31'd100, 31'h00010000, 31'd1};
      foreach (tols[i]) begin
         write_tolerance(i == 2 ? 31'($urandom_range(1, 150)) : tols[i]);
         for (int j = 0; j < 60; j++) send_op(random_op(FUNC_NEAR));
         test_random_ops(20);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      test_random_ops(200);
      wait_drained();
   endtask

   initial begin
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_bus.valid <= 1'b0;
      req_bus.func  <= '0;
      req_bus.a_re  <= '0;
      req_bus.a_im  <= '0;
      req_bus.b_re  <= '0;
      req_bus.b_im  <= '0;
      tol_model = TOLERANCE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_tolerance_settings();
      test_backpressure();
      test_random_ops(930);
      // final stretch at full rate on both sides
      idle_enable = 1'b0;
      test_random_ops(150);
      wait_drained();

      $display("covered %0d results: add %0d sub %0d mul %0d div %0d near %0d other %0d",
               result_count, op_count[0], op_count[1], op_count[2], op_count[3],
               op_count[4], op_count[5] + op_count[6] + op_count[7]);
      if (error_count == 0 && expected_results.size() == 0)
         $display("complex_arith_unit_tb OK");
      else
         $display("complex_arith_unit_tb NOT OK");
      $finish;
   end

endmodule
